// ===== sv/ssp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the scale-space peak detector.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int MAX_COLS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int GCOL_W   = 11;
    localparam int ECOL_W   = ($clog2(MAX_COLS + 1) > GCOL_W) ? $clog2(MAX_COLS + 1) : GCOL_W;
    localparam int ROW_W    = 16;
    localparam int OCT_W    = 3;
    localparam int RESP_W   = 32;
    localparam int COORD_W  = 16;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_THRESHOLD,
        REG_GRID_COLS,
        REG_GRID_ROWS,
        REG_OCTAVE
    } t_reg_idx;

    typedef struct packed {
        logic signed [RESP_W-1:0] lo;
        logic signed [RESP_W-1:0] mid;
        logic signed [RESP_W-1:0] hi;
        logic                     pol;
    } t_sample;

    localparam int SAMPLE_W = $bits(t_sample);

endpackage

// ===== sv/ssp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_in_if
// Request channel: three layer responses and the tested-layer polarity.
// ----------------------------------------------------------------------------
interface ssp_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [ssp_pkg::RESP_W-1:0] resp_below;
    logic signed [ssp_pkg::RESP_W-1:0] resp_centre;
    logic signed [ssp_pkg::RESP_W-1:0] resp_above;
    logic                              trace_positive;

    modport source (output valid, resp_below, resp_centre, resp_above, trace_positive,
                    input ready);
    modport sink   (input valid, resp_below, resp_centre, resp_above, trace_positive,
                    output ready);
endinterface

// ===== sv/ssp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_out_if
// Result channel: peak coordinates, value and polarity.
// ----------------------------------------------------------------------------
interface ssp_out_if;
    logic                               valid;
    logic                               ready;
    logic        [ssp_pkg::COORD_W-1:0] peak_x;
    logic        [ssp_pkg::COORD_W-1:0] peak_y;
    logic signed [ssp_pkg::RESP_W-1:0]  peak_value;
    logic                               peak_polarity;

    modport source (output valid, peak_x, peak_y, peak_value, peak_polarity,
                    input ready);
    modport sink   (input valid, peak_x, peak_y, peak_value, peak_polarity,
                    output ready);
endinterface

// ===== sv/scale_space_peak_detect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scale_space_peak_detect
// 3x3x3 non-maximum suppression over three scale layers of one octave.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one grid point per request in raster order: the responses
//   of the layer below, the tested layer and the layer above (signed Q16.16)
//   and the tested layer's trace polarity. o_peak carries one request for
//   each centre that reaches the threshold and has no strictly greater value
//   among its 26 neighbours; the centre is one row up and one column left of
//   the point that completes its window. Border points are never tested.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle; writing the geometry or the octave restarts the frame.
//   Throughput: one request per cycle while the receiver does not stall. A
//   result reaches o_peak through three register stages (line store read,
//   window shift, compare into the output register).
//   The line store is a single-port-read, single-port-write memory holding
//   both stored rows side by side, read at accept and written back at the
//   next pipeline advance at the same column.
//   Reset clears the pipeline and the counters and resets the registers;
//   the line store keeps its contents, whose stale data a frame started
//   at its first point never uses in a result. When the receiver stalls,
//   the whole pipeline holds and i_req.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module scale_space_peak_detect (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ssp_in_if.sink                         i_req,
    ssp_out_if.source                      o_peak,
    input  logic                           i_cfg_we,
    input  logic [ssp_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [ssp_pkg::CFG_W-1:0]      i_cfg_data
);
    import ssp_pkg::*;

    // configuration registers
    logic signed [RESP_W-1:0] r_threshold;
    logic [GCOL_W-1:0]        r_grid_cols;
    logic [ROW_W-1:0]         r_grid_rows;
    logic [OCT_W-1:0]         r_octave;

    // frame position of the next request
    logic [COL_W-1:0]         r_col;
    logic [ROW_W-1:0]         r_row;

    // stage 1: accepted sample, line store read in flight
    logic                     r_s1_valid;
    t_sample                  r_s1_smp;
    logic [COL_W-1:0]         r_s1_col;
    logic [ROW_W-1:0]         r_s1_row;
    logic [2*SAMPLE_W-1:0]    r_rd_data;

    // stage 2: window holds the neighbourhood
    logic                     r_s2_valid;
    logic [COL_W-1:0]         r_s2_col;
    logic [ROW_W-1:0]         r_s2_row;
    t_sample                  r_win [3][3];

    // output register
    logic                     r_out_valid;
    logic [COORD_W-1:0]       r_peak_x;
    logic [COORD_W-1:0]       r_peak_y;
    logic signed [RESP_W-1:0] r_peak_value;
    logic                     r_peak_pol;

    // line store: upper half is the older row, lower half the newer one
    logic [2*SAMPLE_W-1:0]    mem [MAX_COLS];

    logic                     adv;
    logic                     accept;
    t_sample                  in_smp;
    t_sample                  top_smp;
    t_sample                  mid_smp;
    logic [ECOL_W-1:0]        eff_cols;
    logic [ROW_W-1:0]         eff_rows;
    logic [ECOL_W-1:0]        col_inc;
    logic [ROW_W:0]           row_inc;
    logic [COL_W-1:0]         n_col;
    logic [ROW_W-1:0]         n_row;
    logic                     hit;
    logic [OCT_W:0]           shift;

    // the whole pipeline moves together; hold everything while a result waits
    assign adv         = !r_out_valid || o_peak.ready;
    assign i_req.ready = adv;
    assign accept      = i_req.valid && adv;

    assign in_smp.lo  = i_req.resp_below;
    assign in_smp.mid = i_req.resp_centre;
    assign in_smp.hi  = i_req.resp_above;
    assign in_smp.pol = i_req.trace_positive;

    assign top_smp = t_sample'(r_rd_data[2*SAMPLE_W-1:SAMPLE_W]);
    assign mid_smp = t_sample'(r_rd_data[SAMPLE_W-1:0]);

    // clamp geometry to the supported range
    always_comb begin
        if (ECOL_W'(r_grid_cols) < ECOL_W'(3)) begin
            eff_cols = ECOL_W'(3);
        end else if (ECOL_W'(r_grid_cols) > ECOL_W'(MAX_COLS)) begin
            eff_cols = ECOL_W'(MAX_COLS);
        end else begin
            eff_cols = ECOL_W'(r_grid_cols);
        end
        eff_rows = (r_grid_rows < ROW_W'(3)) ? ROW_W'(3) : r_grid_rows;
    end

    // advance the raster position
    always_comb begin
        col_inc = ECOL_W'(r_col) + ECOL_W'(1);
        row_inc = {1'b0, r_row} + (ROW_W+1)'(1);
        if (col_inc >= eff_cols) begin
            n_col = '0;
            n_row = (row_inc >= {1'b0, eff_rows}) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = r_row;
        end
    end

    // drop the centre unless it is an interior point, reaches the threshold and no neighbour beats it
    always_comb begin
        logic signed [RESP_W-1:0] v;
        v   = r_win[1][1].mid;
        hit = (r_s2_col >= COL_W'(2)) && (r_s2_row >= ROW_W'(2)) && (v >= r_threshold);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if ((r_win[i][j].lo > v) || (r_win[i][j].mid > v) || (r_win[i][j].hi > v)) begin
                    hit = 1'b0;
                end
            end
        end
    end

    assign shift = {1'b0, r_octave} + (OCT_W+1)'(1);

    // configuration and frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_grid_cols <= GCOL_W'(1024);
            r_grid_rows <= ROW_W'(1024);
            r_octave    <= '0;
            r_col       <= '0;
            r_row       <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[RESP_W-1:0];
                end
                REG_GRID_COLS: begin
                    r_grid_cols <= i_cfg_data[GCOL_W-1:0];
                    r_col       <= '0;
                    r_row       <= '0;
                end
                REG_GRID_ROWS: begin
                    r_grid_rows <= i_cfg_data[ROW_W-1:0];
                    r_col       <= '0;
                    r_row       <= '0;
                end
                REG_OCTAVE: begin
                    r_octave <= i_cfg_data[OCT_W-1:0];
                    r_col    <= '0;
                    r_row    <= '0;
                end
            endcase
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line store: read at accept, write back the shifted rows at the next pipeline advance
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= mem[r_col];
        end
        if (r_s1_valid && adv) begin
            mem[r_s1_col] <= {mid_smp, r_s1_smp};
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= i_req.valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && hit;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_smp <= in_smp;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
        end
        if (r_s1_valid && adv) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= top_smp;
            r_win[1][2] <= mid_smp;
            r_win[2][2] <= r_s1_smp;
            r_s2_col    <= r_s1_col;
            r_s2_row    <= r_s1_row;
        end
        if (r_s2_valid && adv) begin
            r_peak_x     <= COORD_W'(32'(r_s2_col - COL_W'(1)) << shift);
            r_peak_y     <= COORD_W'(32'(r_s2_row - ROW_W'(1)) << shift);
            r_peak_value <= r_win[1][1].mid;
            r_peak_pol   <= r_win[1][1].pol;
        end
    end

    assign o_peak.valid         = r_out_valid;
    assign o_peak.peak_x        = r_peak_x;
    assign o_peak.peak_y        = r_peak_y;
    assign o_peak.peak_value    = r_peak_value;
    assign o_peak.peak_polarity = r_peak_pol;

    // a geometry or octave write restarts the frame
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx != REG_THRESHOLD)) |=> (r_col == '0 && r_row == '0))
        else $error("frame position not cleared by geometry write");

    // the raster column stays inside the active row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ECOL_W'(r_col) < eff_cols))
        else $error("column counter beyond row length");

    // a stalled read keeps its line store data
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv) |=> $stable(r_rd_data))
        else $error("line store read data lost during stall");

    // a result always comes from a sample in the window stage
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s2_valid))
        else $error("result without a tested sample");

    // with the output register empty the request side is open
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_req.ready)
        else $error("request side closed with empty output register");

endmodule
